FILE: rtl/core/rbmsi_pkg.sv
// ----------------------------------------------------------------------------
// Relay bank package
// Shared types, widths, codes and helpers for the relay bank with a minimum
// switching interval per channel.
// ----------------------------------------------------------------------------
package rbmsi_pkg;

  // Number of relay channels in the bank (1 to 8).
  localparam int NUM_CHANNELS = 8;

  // Field widths.
  localparam int ACTION_W  = 3;
  localparam int CHANNEL_W = 4;
  localparam int MASK_W    = 8;
  localparam int MS_W      = 32;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 8;

  typedef logic [MS_W-1:0]         ms_t;
  typedef logic [NUM_CHANNELS-1:0] chan_vec_t;

  // Actions carried by one request.
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK       = 3'd0,
    ACT_ACTIVATE   = 3'd1,
    ACT_DEACTIVATE = 3'd2,
    ACT_TOGGLE     = 3'd3,
    ACT_SET_MASK   = 3'd4,
    ACT_ALL_OFF    = 3'd5
  } action_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_CONFIGURED   = 2'd1,
    CFG_INVERTED     = 2'd2
  } cfg_idx_t;

  // One result item.
  typedef struct packed {
    logic               ok;
    logic [MASK_W-1:0]  state_mask;
    logic [MASK_W-1:0]  drive_levels;
    logic [COUNT_W-1:0] configured_count;
  } result_t;

  // Population count of an eight-bit mask.
  function automatic logic [COUNT_W-1:0] popcount8(input logic [MASK_W-1:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + COUNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/relay_bank_min_switch_interval_top.sv
// ----------------------------------------------------------------------------
// Relay bank with minimum switching interval
// Stream front end, state registers and result register of the relay bank.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle while the result stream does
// not stall it, and returns exactly one result for each: a request is
// captured in an input register, evaluated in a single pass against the relay
// states, the switch times and the millisecond counter, and the result is held
// in an output register that frees again in the cycle it is taken. The rate is
// set by the read-modify-write of the channel state, where all channels are
// checked in parallel with one subtract and compare each. Configuration
// writes are accepted in every cycle and must be issued only while no request
// is in flight; a write to the configured mask clears the relay state and the
// switch time of every channel whose bit changes.
module relay_bank_min_switch_interval_top
  import rbmsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Request stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: channel [3:0], wanted_mask [11:4], zero [15:12].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action [2:0], zero [7:3].
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: state_mask [7:0], drive_levels [15:8], configured_count [19:16],
  // zero [23:20].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: ok [0], zero [7:1].
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MS_W-1:0]       cfg_data
);

  // Input register.
  logic                 in_valid;
  logic [ACTION_W-1:0]  in_action;
  logic [CHANNEL_W-1:0] in_channel;
  logic [MASK_W-1:0]    in_wanted;

  // Output register.
  logic                 out_valid;
  result_t              out_result;

  // Configuration and state.
  ms_t                  min_interval_ms;
  logic [MASK_W-1:0]    configured_mask;
  logic [MASK_W-1:0]    inverted_mask;
  ms_t                  now_ms;
  ms_t                  last_switch [NUM_CHANNELS];
  chan_vec_t            relay_on;

  // Step results.
  ms_t                  now_ms_next;
  ms_t                  last_switch_next [NUM_CHANNELS];
  chan_vec_t            relay_on_next;
  result_t              step_result;

  logic                 advance;
  logic                 cfg_write;
  logic [MASK_W-1:0]    cfg_changed;

  // Handshake control.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;
  assign cfg_write     = cfg_valid && cfg_ready;
  assign cfg_changed   = cfg_data[MASK_W-1:0] ^ configured_mask;

  // Input register capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action  <= s_axis_tuser[ACTION_W-1:0];
      in_channel <= s_axis_tdata[CHANNEL_W-1:0];
      in_wanted  <= s_axis_tdata[CHANNEL_W+MASK_W-1:CHANNEL_W];
    end
  end

  rbmsi_step u_step (
    .action           (in_action),
    .channel          (in_channel),
    .wanted_mask      (in_wanted),
    .now_ms           (now_ms),
    .last_switch      (last_switch),
    .relay_on         (relay_on),
    .min_interval_ms  (min_interval_ms),
    .configured_mask  (configured_mask),
    .inverted_mask    (inverted_mask),
    .now_ms_next      (now_ms_next),
    .last_switch_next (last_switch_next),
    .relay_on_next    (relay_on_next),
    .result           (step_result)
  );

  // Configuration registers and channel state.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval_ms <= ms_t'(50);
      configured_mask <= '0;
      inverted_mask   <= '0;
      now_ms          <= '0;
      relay_on        <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_switch[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_INTERVAL: begin
          min_interval_ms <= cfg_data;
        end
        CFG_CONFIGURED: begin
          configured_mask <= cfg_data[MASK_W-1:0];
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (cfg_changed[i]) begin
              relay_on[i]    <= 1'b0;
              last_switch[i] <= '0;
            end
          end
        end
        CFG_INVERTED: begin
          inverted_mask <= cfg_data[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      now_ms   <= now_ms_next;
      relay_on <= relay_on_next;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_switch[i] <= last_switch_next[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - 2*MASK_W - COUNT_W)'(0),
                          out_result.configured_count,
                          out_result.drive_levels,
                          out_result.state_mask};
  assign m_axis_tuser  = {(OUT_USER_W - 1)'(0), out_result.ok};

  // A relay is never on unless its channel is configured.
  a_relay_configured: assert property (@(posedge clk) disable iff (rst)
    (relay_on & ~configured_mask[NUM_CHANNELS-1:0]) == '0)
    else $error("relay on for an unconfigured channel");

  // A tick request advances the millisecond counter by one.
  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    advance && !cfg_write && (action_t'(in_action) == ACT_TICK)
    |=> now_ms == $past(now_ms) + ms_t'(1))
    else $error("tick did not advance the time");

  // Channel state only changes on an evaluated request or a config write.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance && !cfg_write |=> $stable(relay_on) && $stable(now_ms))
    else $error("channel state changed without a request");

  // The reported count never exceeds the number of channels.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_result.configured_count <= COUNT_W'(NUM_CHANNELS))
    else $error("configured count out of range");

endmodule

FILE: rtl/core/rbmsi_step.sv
// ----------------------------------------------------------------------------
// Relay bank step logic
// Combinational next state and result for one request, from the current
// relay states, switch times and configuration.
// ----------------------------------------------------------------------------
module rbmsi_step
  import rbmsi_pkg::*;
(
  input  logic [ACTION_W-1:0]  action,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [MASK_W-1:0]    wanted_mask,
  input  ms_t                  now_ms,
  input  ms_t                  last_switch [NUM_CHANNELS],
  input  chan_vec_t            relay_on,
  input  ms_t                  min_interval_ms,
  input  logic [MASK_W-1:0]    configured_mask,
  input  logic [MASK_W-1:0]    inverted_mask,
  output ms_t                  now_ms_next,
  output ms_t                  last_switch_next [NUM_CHANNELS],
  output chan_vec_t            relay_on_next,
  output result_t              result
);

  chan_vec_t cfg_eff;
  chan_vec_t inv_eff;
  chan_vec_t interval_met;
  chan_vec_t sel;
  chan_vec_t target;
  logic      ok;

  assign cfg_eff = configured_mask[NUM_CHANNELS-1:0];
  assign inv_eff = inverted_mask[NUM_CHANNELS-1:0];

  // Per-channel interval check on the wrapped elapsed time.
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      interval_met[i] = (now_ms - last_switch[i]) >= min_interval_ms;
    end
  end

  // Decode the action into switch requests per channel.
  always_comb begin
    now_ms_next = now_ms;
    sel         = '0;
    target      = '0;
    ok          = 1'b0;
    case (action_t'(action))
      ACT_TICK: begin
        now_ms_next = now_ms + ms_t'(1);
        ok          = 1'b1;
      end
      ACT_ACTIVATE, ACT_DEACTIVATE, ACT_TOGGLE: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          sel[i] = (channel == CHANNEL_W'(i)) && cfg_eff[i];
        end
        if (action_t'(action) == ACT_ACTIVATE) begin
          target = '1;
        end else if (action_t'(action) == ACT_DEACTIVATE) begin
          target = '0;
        end else begin
          target = ~relay_on;
        end
        ok = |(sel & interval_met);
      end
      ACT_SET_MASK: begin
        sel    = cfg_eff;
        target = wanted_mask[NUM_CHANNELS-1:0];
        ok     = 1'b1;
      end
      ACT_ALL_OFF: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Apply checked switches; all-off clears configured channels unchecked.
  always_comb begin
    relay_on_next = relay_on;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      last_switch_next[i] = last_switch[i];
      if (sel[i] && interval_met[i]) begin
        relay_on_next[i]    = target[i];
        last_switch_next[i] = now_ms;
      end
    end
    if (action_t'(action) == ACT_ALL_OFF) begin
      relay_on_next = relay_on & ~cfg_eff;
    end
  end

  // Result fields after the step.
  assign result.ok               = ok;
  assign result.state_mask       = MASK_W'(relay_on_next);
  assign result.drive_levels     = MASK_W'((relay_on_next ^ inv_eff) & cfg_eff);
  assign result.configured_count = popcount8(MASK_W'(cfg_eff));

endmodule
